FILE: rtl/core/lrsf_pkg.sv
`default_nettype none
package lrsf_pkg;

	localparam int DEF_SESSION_IDS = 256 * 256;
	localparam int DEF_TAG_CODES = 256;
	localparam int Q_DEPTH = 2;

	localparam int CLS_CLIENT_BIT = 0;
	localparam int CLS_BACKEND_BIT = 1;
	localparam int RULE_SELECT_BIT = 0;
	localparam int RULE_SUPPRESS_BIT = 1;

	localparam logic [1:0] CLS_CLIENT = 2'(1 << CLS_CLIENT_BIT);
	localparam logic [1:0] CLS_BACKEND = 2'(1 << CLS_BACKEND_BIT);

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic [CFG_ADDR_W-1:0] CFG_BACKEND_ONLY = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_CLIENT_ONLY = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_SKIP_COUNT = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_KEEP_COUNT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_SESSION_OPEN_TAG = 3'd4;
	localparam logic [CFG_ADDR_W-1:0] CFG_REQUEST_START_TAG = 3'd5;
	localparam logic [CFG_ADDR_W-1:0] CFG_BACKEND_OPEN_TAG = 3'd6;
	localparam logic [CFG_ADDR_W-1:0] CFG_BACKEND_XID_TAG = 3'd7;

	localparam logic [7:0] RST_SESSION_OPEN_TAG = 8'd0;
	localparam logic [7:0] RST_REQUEST_START_TAG = 8'd1;
	localparam logic [7:0] RST_BACKEND_OPEN_TAG = 8'd2;
	localparam logic [7:0] RST_BACKEND_XID_TAG = 8'd3;

	typedef enum logic {
		REQ_RECORD = 1'b0,
		REQ_RULE   = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		ST_DROP    = 2'd0,
		ST_DELIVER = 2'd1,
		ST_LIMIT   = 2'd2,
		ST_RULE    = 2'd3
	} status_t;

	typedef struct packed {
		req_t        req_type;
		logic [7:0]  tag;
		logic [15:0] session_id;
		logic        rule_select;
		logic        rule_suppress;
	} in_t;

	typedef struct packed {
		status_t     status;
		logic [7:0]  out_tag;
		logic [15:0] out_session;
		logic        is_client;
		logic        is_backend;
	} out_t;

	typedef struct packed {
		logic        backend_only;
		logic        client_only;
		logic [31:0] skip_count;
		logic [31:0] keep_count;
		logic [7:0]  session_open_tag;
		logic [7:0]  request_start_tag;
		logic [7:0]  backend_open_tag;
		logic [7:0]  backend_xid_tag;
	} cfg_t;

	typedef struct packed {
		req_t        kind;
		logic [7:0]  tag;
		logic [15:0] session_id;
		logic [1:0]  cls;
		logic [1:0]  rule;
	} q_item_t;

	// remainder by restoring subtraction, quotient below 256
	function automatic logic [15:0] lrsf_reduce(input logic [15:0] val, input logic [20:0] n);
		logic [31:0] r;
		logic [31:0] d;
		r = 32'(val);
		for (int k = 7; k >= 0; k--) begin
			d = 32'(n) << k;
			if (r >= d) begin
				r = r - d;
			end
		end
		return r[15:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/core/lrsf_front.sv
`default_nettype none
module lrsf_front #(
	parameter int SESSION_IDS = lrsf_pkg::DEF_SESSION_IDS,
	parameter int TAG_CODES = lrsf_pkg::DEF_TAG_CODES
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lrsf_pkg::cfg_t   cfg,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire lrsf_pkg::in_t    in_word,
	output logic                  push,
	output lrsf_pkg::q_item_t     push_item,
	input  wire logic             q_full,
	output logic                  busy
);
	import lrsf_pkg::*;

	localparam int SID_W = $clog2(SESSION_IDS);
	localparam int TAG_W = $clog2(TAG_CODES);

	logic [1:0] cls_mem [SESSION_IDS];
	logic [1:0] rule_mem [TAG_CODES];

	logic             clr_busy_q;
	logic [SID_W-1:0] clr_idx_q;

	logic             valid_s1;
	in_t              word_s1;
	logic [SID_W-1:0] sid_ix_s1;
	logic [TAG_W-1:0] tag_ix_s1;
	logic [1:0]       cls_rd_s1;
	logic [1:0]       rule_rd_s1;

	logic             fcls_vld_q;
	logic [SID_W-1:0] fcls_ix_q;
	logic [1:0]       fcls_q;
	logic             frule_vld_q;
	logic [TAG_W-1:0] frule_ix_q;
	logic [1:0]       frule_q;

	logic             accept;
	logic             advance;
	logic [SID_W-1:0] sid_ix;
	logic [TAG_W-1:0] tag_ix;
	logic [1:0]       cls_old;
	logic [1:0]       cls_new;
	logic [1:0]       rule_cur;
	logic [1:0]       rule_new;
	logic             match_client;
	logic             match_backend;
	logic             cls_we;
	logic [SID_W-1:0] cls_wa;
	logic [1:0]       cls_wd;
	logic             rule_we;
	logic [TAG_W-1:0] rule_wa;
	logic [1:0]       rule_wd;
	logic             rec_adv;
	logic             rule_adv;

	assign advance = valid_s1 && !q_full;
	assign in_stall = clr_busy_q || (valid_s1 && q_full);
	assign accept = in_valid && !in_stall;
	assign busy = clr_busy_q;

	assign sid_ix = SID_W'(lrsf_reduce(in_word.session_id, 21'(SESSION_IDS)));
	assign tag_ix = TAG_W'(lrsf_reduce(16'(in_word.tag), 21'(TAG_CODES)));

	assign rec_adv = advance && (word_s1.req_type == REQ_RECORD);
	assign rule_adv = advance && (word_s1.req_type == REQ_RULE);

	always_comb begin
		match_client = (word_s1.tag == cfg.session_open_tag) ||
			(word_s1.tag == cfg.request_start_tag);
		match_backend = (word_s1.tag == cfg.backend_open_tag) ||
			(word_s1.tag == cfg.backend_xid_tag);
		cls_old = (fcls_vld_q && fcls_ix_q == sid_ix_s1) ? fcls_q : cls_rd_s1;
		if (match_client) begin
			cls_new = CLS_CLIENT;
		end else if (match_backend) begin
			cls_new = CLS_BACKEND;
		end else begin
			cls_new = cls_old;
		end
		rule_cur = (frule_vld_q && frule_ix_q == tag_ix_s1) ? frule_q : rule_rd_s1;
		rule_new = '0;
		rule_new[RULE_SELECT_BIT] = word_s1.rule_select;
		rule_new[RULE_SUPPRESS_BIT] = word_s1.rule_suppress;
	end

	// clearing sweep shares the write ports
	always_comb begin
		cls_we = clr_busy_q || rec_adv;
		cls_wa = clr_busy_q ? clr_idx_q : sid_ix_s1;
		cls_wd = clr_busy_q ? 2'b00 : cls_new;
		rule_we = (clr_busy_q && ({1'b0, clr_idx_q} < (SID_W+1)'(TAG_CODES))) || rule_adv;
		rule_wa = clr_busy_q ? TAG_W'(clr_idx_q) : tag_ix_s1;
		rule_wd = clr_busy_q ? 2'b00 : rule_new;
	end

	always_ff @(posedge clk) begin
		if (cls_we) begin
			cls_mem[cls_wa] <= cls_wd;
		end
		if (accept) begin
			cls_rd_s1 <= cls_mem[sid_ix];
		end
	end

	always_ff @(posedge clk) begin
		if (rule_we) begin
			rule_mem[rule_wa] <= rule_wd;
		end
		if (accept) begin
			rule_rd_s1 <= rule_mem[tag_ix];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_busy_q) begin
			clr_idx_q <= clr_idx_q + SID_W'(1);
			if (clr_idx_q == SID_W'(SESSION_IDS - 1)) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= in_word;
			sid_ix_s1 <= sid_ix;
			tag_ix_s1 <= tag_ix;
		end
	end

	// last value written, for a read issued on the same edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fcls_vld_q <= 1'b0;
			frule_vld_q <= 1'b0;
		end else begin
			if (rec_adv) begin
				fcls_vld_q <= 1'b1;
			end
			if (rule_adv) begin
				frule_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rec_adv) begin
			fcls_ix_q <= sid_ix_s1;
			fcls_q <= cls_new;
		end
		if (rule_adv) begin
			frule_ix_q <= tag_ix_s1;
			frule_q <= rule_new;
		end
	end

	assign push = advance;

	always_comb begin
		push_item.kind = word_s1.req_type;
		push_item.tag = word_s1.tag;
		push_item.session_id = word_s1.session_id;
		push_item.cls = cls_new;
		push_item.rule = rule_cur;
	end

endmodule
`default_nettype wire

FILE: rtl/core/lrsf_queue.sv
`default_nettype none
module lrsf_queue #(
	parameter int DEPTH = lrsf_pkg::Q_DEPTH
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire lrsf_pkg::q_item_t push_item,
	output logic                   full,
	input  wire logic              pop,
	output lrsf_pkg::q_item_t      pop_item,
	output logic                   not_empty
);
	import lrsf_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	q_item_t        mem_q [DEPTH];
	logic [PW-1:0]  wptr_q;
	logic [PW-1:0]  rptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign full = (count_q == CW'(DEPTH));
	assign not_empty = (count_q != '0);
	assign do_push = push && !full;
	assign do_pop = pop && not_empty;
	assign pop_item = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

FILE: rtl/core/lrsf_back.sv
`default_nettype none
module lrsf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lrsf_pkg::cfg_t    cfg,
	input  wire logic              q_valid,
	input  wire lrsf_pkg::q_item_t q_item,
	output logic                   pop,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output lrsf_pkg::out_t         out_word
);
	import lrsf_pkg::*;

	logic [31:0] skipped_q;
	logic [31:0] kept_q;
	logic        fin_q;
	logic        out_valid_q;
	out_t        out_q;

	logic [31:0] skipped_d;
	logic [31:0] kept_d;
	logic        fin_d;
	status_t     status;
	out_t        res;

	assign pop = q_valid && !(out_valid_q && out_stall);

	always_comb begin
		skipped_d = skipped_q;
		kept_d = kept_q;
		fin_d = fin_q;
		status = ST_DROP;
		if (q_item.kind == REQ_RULE) begin
			status = ST_RULE;
		end else if (skipped_q < cfg.skip_count) begin
			skipped_d = skipped_q + 32'd1;
		end else begin
			status = ST_DELIVER;
			if (cfg.keep_count != '0 && !fin_q) begin
				kept_d = kept_q + 32'd1;
				if (kept_d >= cfg.keep_count) begin
					fin_d = 1'b1;
					status = ST_LIMIT;
				end
			end
			if (status == ST_DELIVER && !q_item.rule[RULE_SELECT_BIT]) begin
				if (q_item.rule[RULE_SUPPRESS_BIT]) begin
					status = ST_DROP;
				end else if (cfg.backend_only && !q_item.cls[CLS_BACKEND_BIT]) begin
					status = ST_DROP;
				end else if (cfg.client_only && !q_item.cls[CLS_CLIENT_BIT]) begin
					status = ST_DROP;
				end
			end
		end
		res.status = status;
		res.out_tag = q_item.tag;
		if (q_item.kind == REQ_RULE) begin
			res.out_session = '0;
			res.is_client = 1'b0;
			res.is_backend = 1'b0;
		end else begin
			res.out_session = q_item.session_id;
			res.is_client = q_item.cls[CLS_CLIENT_BIT];
			res.is_backend = q_item.cls[CLS_BACKEND_BIT];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skipped_q <= '0;
			kept_q <= '0;
			fin_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				skipped_q <= skipped_d;
				kept_q <= kept_d;
				fin_q <= fin_d;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			out_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_q;

endmodule
`default_nettype wire

FILE: rtl/core/log_record_session_filter.sv
// Log record session filter. Takes one record header or tag-rule write per cycle on the
// in_word channel while in_stall is low and returns exactly one result word for each on
// out_word. Sustained rate is one word per clock while out_stall stays low; a word passes
// the table read stage, then the two-entry queue, which loads the output register as it
// pops. The session and tag tables sit in single-port write / single-port read memories
// updated in the read stage, with a bypass of the last write so consecutive records of one
// session see each other's marks. After reset the tables are swept to zero, one session
// entry per cycle, so in_stall stays high until all SESSION_IDS entries (65536 by default)
// are cleared; configuration writes are taken during the sweep.
// Configuration should change only while no word is in flight.
`default_nettype none
module log_record_session_filter #(
	parameter int SESSION_IDS = lrsf_pkg::DEF_SESSION_IDS,
	parameter int TAG_CODES = lrsf_pkg::DEF_TAG_CODES
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_write,
	input  wire logic [lrsf_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  wire logic [lrsf_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire lrsf_pkg::in_t                      in_word,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output lrsf_pkg::out_t                          out_word
);
	import lrsf_pkg::*;

	cfg_t    cfg_q;
	logic    push;
	q_item_t push_item;
	logic    q_full;
	logic    q_not_empty;
	q_item_t q_item;
	logic    pop;
	logic    busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.backend_only <= 1'b0;
			cfg_q.client_only <= 1'b0;
			cfg_q.skip_count <= '0;
			cfg_q.keep_count <= '0;
			cfg_q.session_open_tag <= RST_SESSION_OPEN_TAG;
			cfg_q.request_start_tag <= RST_REQUEST_START_TAG;
			cfg_q.backend_open_tag <= RST_BACKEND_OPEN_TAG;
			cfg_q.backend_xid_tag <= RST_BACKEND_XID_TAG;
		end else if (cfg_write) begin
			unique case (cfg_addr)
				CFG_BACKEND_ONLY: cfg_q.backend_only <= cfg_data[0];
				CFG_CLIENT_ONLY: cfg_q.client_only <= cfg_data[0];
				CFG_SKIP_COUNT: cfg_q.skip_count <= cfg_data[31:0];
				CFG_KEEP_COUNT: cfg_q.keep_count <= cfg_data[31:0];
				CFG_SESSION_OPEN_TAG: cfg_q.session_open_tag <= cfg_data[7:0];
				CFG_REQUEST_START_TAG: cfg_q.request_start_tag <= cfg_data[7:0];
				CFG_BACKEND_OPEN_TAG: cfg_q.backend_open_tag <= cfg_data[7:0];
				CFG_BACKEND_XID_TAG: cfg_q.backend_xid_tag <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	lrsf_front #(
		.SESSION_IDS(SESSION_IDS),
		.TAG_CODES(TAG_CODES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.push(push),
		.push_item(push_item),
		.q_full(q_full),
		.busy(busy)
	);

	lrsf_queue #(
		.DEPTH(Q_DEPTH)
	) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.full(q_full),
		.pop(pop),
		.pop_item(q_item),
		.not_empty(q_not_empty)
	);

	lrsf_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.q_valid(q_not_empty),
		.q_item(q_item),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	a_sweep_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> in_stall)
		else $error("word accepted during table sweep");

	a_single_mark: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_word.is_client && out_word.is_backend))
		else $error("session marked client and backend");

	a_rule_result_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_word.status == ST_RULE) |->
		(out_word.out_session == '0 && !out_word.is_client && !out_word.is_backend))
		else $error("rule result carries session data");

	a_no_push_while_sweeping: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !push)
		else $error("queue written during table sweep");

endmodule
`default_nettype wire

FILE: bench/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import lrsf_pkg::*;

	localparam int QUIET_LIMIT = 300000;
	localparam int HOLD_CYCLES = 150;
	localparam int PHASE_WORDS = 155;
	localparam int PHASES = 8;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_t in_word = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_t out_word;

	log_record_session_filter dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_addr(cfg_addr),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_word(in_word),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_word(out_word)
	);

	always begin
		#4ns clk = 1'b1;
		#4ns clk = 1'b0;
	end

	// filter state as the block should hold it
	cfg_t cfg;
	logic [1:0] sess_mark [0:DEF_SESSION_IDS-1];
	logic [1:0] tag_rule [0:DEF_TAG_CODES-1];
	logic [31:0] skipped_n;
	logic [31:0] kept_n;
	logic keep_done;

	in_t pending_words [$];
	out_t results_due [$];

	int src_idle_pct = 0;
	int snk_stall_pct = 0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	logic in_fired = 1'b0;
	int quiet_cycles = 0;
	int errors = 0;
	int n_deliver = 0;
	int n_drop = 0;
	int n_limit = 0;
	int n_rule = 0;
	int n_settings = 0;

	function automatic out_t classify_word(in_t w);
		out_t r;
		logic [1:0] mark;
		logic [1:0] rule;
		r = '0;
		r.out_tag = w.tag;
		if (w.req_type == REQ_RULE) begin
			tag_rule[w.tag] = {w.rule_suppress, w.rule_select};
			r.status = ST_RULE;
			return r;
		end
		mark = sess_mark[w.session_id];
		if (w.tag == cfg.session_open_tag || w.tag == cfg.request_start_tag) begin
			mark = CLS_CLIENT;
		end else if (w.tag == cfg.backend_open_tag || w.tag == cfg.backend_xid_tag) begin
			mark = CLS_BACKEND;
		end
		sess_mark[w.session_id] = mark;
		rule = tag_rule[w.tag];
		if (skipped_n < cfg.skip_count) begin
			skipped_n++;
			r.status = ST_DROP;
		end else begin
			r.status = ST_DELIVER;
			if (cfg.keep_count != 0 && !keep_done) begin
				kept_n++;
				if (kept_n >= cfg.keep_count) begin
					keep_done = 1'b1;
					r.status = ST_LIMIT;
				end
			end
			if (r.status == ST_DELIVER && !rule[RULE_SELECT_BIT]) begin
				if (rule[RULE_SUPPRESS_BIT]) begin
					r.status = ST_DROP;
				end else if (cfg.backend_only && !mark[CLS_BACKEND_BIT]) begin
					r.status = ST_DROP;
				end else if (cfg.client_only && !mark[CLS_CLIENT_BIT]) begin
					r.status = ST_DROP;
				end
			end
		end
		r.out_session = w.session_id;
		r.is_client = mark[CLS_CLIENT_BIT];
		r.is_backend = mark[CLS_BACKEND_BIT];
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 30) begin
			$display("mismatch %s: got %0h want %0h", what, got, want);
		end
	endtask

	// driver: new word only once the previous one has gone
	always @(negedge clk) begin
		if (arst_n && (!in_valid || in_fired)) begin
			if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
				in_valid <= 1'b1;
				in_word <= pending_words.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// receiver stall, with long hold-offs on request
	always @(negedge clk) begin
		if (holds_served != holds_asked) begin
			holds_served++;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < snk_stall_pct);
		end
	end

	// monitor and watchdog
	always @(posedge clk) begin : mon
		out_t want;
		logic out_fired;
		in_fired = in_valid && !in_stall;
		out_fired = out_valid && !out_stall;
		if (in_fired) begin
			results_due.push_back(classify_word(in_word));
		end
		if (out_fired) begin
			if (results_due.size() == 0) begin
				report_mismatch("unexpected word", 32'(out_word), 32'h0);
			end else begin
				want = results_due.pop_front();
				case (want.status)
					ST_DROP:    n_drop++;
					ST_DELIVER: n_deliver++;
					ST_LIMIT:   n_limit++;
					default:    n_rule++;
				endcase
				if (out_word.status !== want.status)
					report_mismatch("status", 32'(out_word.status), 32'(want.status));
				if (out_word.out_tag !== want.out_tag)
					report_mismatch("out_tag", 32'(out_word.out_tag), 32'(want.out_tag));
				if (out_word.out_session !== want.out_session)
					report_mismatch("out_session", 32'(out_word.out_session),
						32'(want.out_session));
				if (out_word.is_client !== want.is_client)
					report_mismatch("is_client", 32'(out_word.is_client), 32'(want.is_client));
				if (out_word.is_backend !== want.is_backend)
					report_mismatch("is_backend", 32'(out_word.is_backend),
						32'(want.is_backend));
			end
		end
		if (in_fired || out_fired) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("timeout: %0d words still due", results_due.size());
			$display("tb_top NOT OK");
			$finish;
		end
	end

	task automatic cfg_put(logic [CFG_ADDR_W-1:0] addr, logic [31:0] val);
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_addr <= addr;
		cfg_data <= val;
		case (addr)
			CFG_BACKEND_ONLY:      cfg.backend_only = val[0];
			CFG_CLIENT_ONLY:       cfg.client_only = val[0];
			CFG_SKIP_COUNT:        cfg.skip_count = val;
			CFG_KEEP_COUNT:        cfg.keep_count = val;
			CFG_SESSION_OPEN_TAG:  cfg.session_open_tag = val[7:0];
			CFG_REQUEST_START_TAG: cfg.request_start_tag = val[7:0];
			CFG_BACKEND_OPEN_TAG:  cfg.backend_open_tag = val[7:0];
			default:               cfg.backend_xid_tag = val[7:0];
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	// checked at the rising edge, where the driver's outputs are settled
	task automatic drain();
		while (pending_words.size() != 0 || in_valid || results_due.size() != 0)
			@(posedge clk);
		repeat (6) @(negedge clk);
	endtask

	function automatic in_t mk(req_t req, logic [7:0] tag, logic [15:0] sess,
			logic sel, logic sup);
		in_t w;
		w.req_type = req;
		w.tag = tag;
		w.session_id = sess;
		w.rule_select = sel;
		w.rule_suppress = sup;
		return w;
	endfunction

	function automatic logic [7:0] pick_tag();
		int r;
		r = $urandom_range(0, 99);
		if (r < 45) begin
			case ($urandom_range(0, 3))
				0: return cfg.session_open_tag;
				1: return cfg.request_start_tag;
				2: return cfg.backend_open_tag;
				default: return cfg.backend_xid_tag;
			endcase
		end else if (r < 85) begin
			return 8'($urandom_range(0, 15));
		end
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic in_t pick_word();
		in_t w;
		int r;
		w.req_type = ($urandom_range(0, 99) < 10) ? REQ_RULE : REQ_RECORD;
		w.tag = pick_tag();
		r = $urandom_range(0, 99);
		if (r < 85) begin
			w.session_id = 16'($urandom_range(0, 7));
		end else if (r < 95) begin
			w.session_id = 16'hFFFF - 16'($urandom_range(0, 7));
		end else begin
			w.session_id = 16'($urandom);
		end
		w.rule_select = 1'($urandom_range(0, 1));
		w.rule_suppress = 1'($urandom_range(0, 1));
		return w;
	endfunction

	task automatic pick_settings(int ph);
		logic [31:0] skip_v;
		logic [31:0] keep_v;
		skip_v = skipped_n + 32'($urandom_range(0, 30));
		keep_v = 32'($urandom_range(1, 60));
		if (ph == 2) skip_v = 32'hFFFF_FFFF;
		if (ph == 3) skip_v = 32'h0;
		if (ph == 6) keep_v = 32'hFFFF_FFFF;
		if (ph == 7) keep_v = 32'h0;
		cfg_put(CFG_BACKEND_ONLY, 32'($urandom_range(0, 1)));
		cfg_put(CFG_CLIENT_ONLY, 32'($urandom_range(0, 1)));
		cfg_put(CFG_SKIP_COUNT, skip_v);
		cfg_put(CFG_KEEP_COUNT, keep_v);
		if (ph == 1) begin
			cfg_put(CFG_SESSION_OPEN_TAG, 32'hFF);
			cfg_put(CFG_REQUEST_START_TAG, 32'hFF);
			cfg_put(CFG_BACKEND_OPEN_TAG, 32'h00);
			cfg_put(CFG_BACKEND_XID_TAG, 32'h00);
		end else begin
			cfg_put(CFG_SESSION_OPEN_TAG, 32'($urandom_range(0, 15)));
			cfg_put(CFG_REQUEST_START_TAG, 32'($urandom_range(0, 15)));
			cfg_put(CFG_BACKEND_OPEN_TAG, 32'($urandom_range(0, 15)));
			cfg_put(CFG_BACKEND_XID_TAG, 32'($urandom_range(0, 15)));
		end
		n_settings++;
	endtask

	initial begin
		cfg = '0;
		cfg.session_open_tag = RST_SESSION_OPEN_TAG;
		cfg.request_start_tag = RST_REQUEST_START_TAG;
		cfg.backend_open_tag = RST_BACKEND_OPEN_TAG;
		cfg.backend_xid_tag = RST_BACKEND_XID_TAG;
		for (int i = 0; i < DEF_SESSION_IDS; i++) sess_mark[i] = '0;
		for (int i = 0; i < DEF_TAG_CODES; i++) tag_rule[i] = '0;
		skipped_n = '0;
		kept_n = '0;
		keep_done = 1'b0;

		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings: rules, marks, selected over suppressed
		pending_words.push_back(mk(REQ_RULE, 8'd5, 16'h0000, 1'b0, 1'b1));
		pending_words.push_back(mk(REQ_RULE, 8'd6, 16'h0000, 1'b1, 1'b0));
		pending_words.push_back(mk(REQ_RULE, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
		pending_words.push_back(mk(REQ_RULE, 8'd0, 16'hFFFF, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd0, 16'h0000, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd1, 16'hFFFF, 1'b1, 1'b1));
		pending_words.push_back(mk(REQ_RECORD, 8'd2, 16'h0001, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd3, 16'h0001, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd5, 16'h0000, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd6, 16'h0002, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'hFF, 16'hFFFF, 1'b1, 1'b1));
		pending_words.push_back(mk(REQ_RECORD, 8'd4, 16'h0000, 1'b0, 1'b0));
		drain();

		// client-only mode
		cfg_put(CFG_CLIENT_ONLY, 32'd1);
		pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0000, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0001, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd6, 16'h0001, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0003, 1'b0, 1'b0));
		drain();

		// backend-only mode
		cfg_put(CFG_CLIENT_ONLY, 32'd0);
		cfg_put(CFG_BACKEND_ONLY, 32'd1);
		pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0001, 1'b0, 1'b0));
		pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0000, 1'b0, 1'b0));
		drain();

		// same tag opens client and backend: client wins
		cfg_put(CFG_BACKEND_ONLY, 32'd0);
		cfg_put(CFG_SESSION_OPEN_TAG, 32'd7);
		cfg_put(CFG_BACKEND_OPEN_TAG, 32'd7);
		pending_words.push_back(mk(REQ_RECORD, 8'd7, 16'h0001, 1'b0, 1'b0));
		drain();

		// skip two, count two, then lower the limit below the count kept
		cfg_put(CFG_SKIP_COUNT, 32'd2);
		cfg_put(CFG_KEEP_COUNT, 32'd3);
		repeat (4) pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0002, 1'b0, 1'b0));
		drain();
		cfg_put(CFG_KEEP_COUNT, 32'd1);
		repeat (2) pending_words.push_back(mk(REQ_RECORD, 8'd9, 16'h0002, 1'b0, 1'b0));
		drain();

		for (int ph = 0; ph < PHASES; ph++) begin
			pick_settings(ph);
			case (ph % 4)
				0: begin src_idle_pct = 0; snk_stall_pct = 0; end
				1: begin src_idle_pct = 86; snk_stall_pct = 0; end
				2: begin src_idle_pct = 0; snk_stall_pct = 86; end
				default: begin src_idle_pct = 7; snk_stall_pct = 7; end
			endcase
			if (ph == 4) holds_asked++;
			for (int i = 0; i < PHASE_WORDS; i++) begin
				pending_words.push_back(pick_word());
				// sender waits for every result halfway through
				if (ph == 5 && i == PHASE_WORDS / 2) drain();
			end
			drain();
		end

		repeat (10) @(negedge clk);
		$display("covered %0d settings, %0d records kept, %0d dropped, %0d at the limit",
			n_settings + 1, n_deliver, n_drop, n_limit);
		$display("and %0d rule writes, with sender and receiver idling and long hold-offs",
			n_rule);
		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("%0d mismatches", errors);
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule
